### src/qmpd_pkg.sv
// ============================================================================
// qmpd_pkg
// Types, constants and decode helpers for the quadrature motor position drive.
// ============================================================================
`default_nettype none

package qmpd_pkg;

  localparam int POSITION_BITS = 32;
  localparam int DUTY_MAX      = 100;
  localparam int DUTY_BITS     = 7;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 8;

  typedef logic signed [POSITION_BITS-1:0] pos_t;
  typedef logic [DUTY_BITS-1:0]            duty_t;
  typedef logic signed [9:0]               duty_sum_t;

  // commands
  localparam logic [2:0] CMD_SAMPLE = 3'd0;
  localparam logic [2:0] CMD_CW     = 3'd1;
  localparam logic [2:0] CMD_CCW    = 3'd2;
  localparam logic [2:0] CMD_STOP   = 3'd3;
  localparam logic [2:0] CMD_LOAD   = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_BOTH_CHANNELS = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COUNT_SENSE   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEFAULT_DUTY  = 2'd2;

  localparam duty_t DEFAULT_DUTY_RESET = duty_t'(50);
  localparam pos_t  STEP_SINGLE        = pos_t'(4);

  function automatic logic step_up(input logic [3:0] code);
    return code inside {4'b1110, 4'b0111, 4'b0001, 4'b1000};
  endfunction

  function automatic logic step_down(input logic [3:0] code);
    return code inside {4'b1101, 4'b0100, 4'b0010, 4'b1011};
  endfunction

endpackage

`default_nettype wire

### src/quadrature_motor_position_drive.sv
// Registered: an accepted request shows its result from the next cycle.
// Throughput: one request per cycle while no result is held or out_ready is
// high; single-pass decode and duty logic between the state registers set it.
// Reset: synchronous, active high; clears position, last code, drive pins and
// duties, and loads registers with two-channel decode, sense 0, default duty 50.
// ============================================================================
// quadrature_motor_position_drive
// Quadrature encoder decoder with target-seeking motor drive and duty choice.
// ============================================================================
`default_nettype none

module quadrature_motor_position_drive (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  [2:0]                          cmd,
  input  wire                                 enc_a,
  input  wire                                 enc_b,
  input  wire  signed [31:0]                  target,
  input  wire  signed [7:0]                   duty_request,
  input  wire                                 relative,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic signed [31:0]                  position,
  output logic                                drive_cw,
  output logic                                drive_ccw,
  output logic [6:0]                          duty_out,
  output logic [6:0]                          duty_setting,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [qmpd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire  [qmpd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import qmpd_pkg::*;

  logic  both_channels;
  logic  count_sense;
  duty_t default_duty;

  logic [1:0] last_code;
  pos_t       position_count;
  logic       dir_cw;
  logic       dir_ccw;
  duty_t      applied_duty;
  duty_t      chosen_duty;

  logic       in_accept;
  logic [3:0] sum_code;
  logic       up;
  logic       down;
  logic       fwd;
  logic       rev;
  pos_t       pos_decoded;
  pos_t       target_pos;
  duty_sum_t  d_sum;
  duty_t      d_pick;
  logic       go;

  logic [1:0] last_code_next;
  pos_t       position_count_next;
  logic       dir_cw_next;
  logic       dir_ccw_next;
  duty_t      applied_duty_next;
  duty_t      chosen_duty_next;

  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign sum_code   = {last_code, enc_a, enc_b};
  assign up         = step_up(sum_code);
  assign down       = step_down(sum_code);
  assign fwd        = dir_cw && !dir_ccw;
  assign rev        = !dir_cw && dir_ccw;
  assign target_pos = pos_t'(target);

  always_comb begin
    pos_decoded = position_count;
    if (both_channels) begin
      if (down) pos_decoded = position_count - pos_t'(1);
      else if (up) pos_decoded = position_count + pos_t'(1);
    end else if (up) begin
      if ((fwd && count_sense) || (rev && !count_sense)) begin
        pos_decoded = position_count + STEP_SINGLE;
      end else if (fwd || rev) begin
        pos_decoded = position_count - STEP_SINGLE;
      end
    end
  end

  always_comb begin
    d_sum = duty_sum_t'(duty_request);
    if (relative) d_sum = d_sum + duty_sum_t'({1'b0, default_duty});
    if (d_sum == '0) d_sum = duty_sum_t'({1'b0, default_duty});
    if (d_sum < 0) d_pick = '0;
    else if (d_sum > duty_sum_t'(DUTY_MAX)) d_pick = duty_t'(DUTY_MAX);
    else d_pick = duty_t'(d_sum);
  end

  assign go = (target > 0 && pos_decoded < target) || (target < 0 && pos_decoded > target);

  always_comb begin
    last_code_next      = {enc_a, enc_b};
    position_count_next = pos_decoded;
    dir_cw_next         = dir_cw;
    dir_ccw_next        = dir_ccw;
    applied_duty_next   = applied_duty;
    chosen_duty_next    = chosen_duty;
    case (cmd)
      CMD_CW, CMD_CCW: begin
        if (go) begin
          dir_cw_next       = (cmd == CMD_CW);
          dir_ccw_next      = (cmd == CMD_CCW);
          chosen_duty_next  = d_pick;
          if (chosen_duty == '0) applied_duty_next = d_pick;
        end else begin
          dir_cw_next       = 1'b0;
          dir_ccw_next      = 1'b0;
          applied_duty_next = '0;
          chosen_duty_next  = '0;
        end
      end
      CMD_STOP: begin
        dir_cw_next       = 1'b0;
        dir_ccw_next      = 1'b0;
        applied_duty_next = '0;
        chosen_duty_next  = '0;
      end
      CMD_LOAD: begin
        position_count_next = target_pos;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      both_channels <= 1'b1;
      count_sense   <= 1'b0;
      default_duty  <= DEFAULT_DUTY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BOTH_CHANNELS: both_channels <= cfg_data[0];
        REG_COUNT_SENSE:   count_sense   <= cfg_data[0];
        REG_DEFAULT_DUTY:  default_duty  <= cfg_data[DUTY_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      last_code      <= '0;
      position_count <= '0;
      dir_cw         <= 1'b0;
      dir_ccw        <= 1'b0;
      applied_duty   <= '0;
      chosen_duty    <= '0;
    end else begin
      if (in_accept) begin
        out_valid      <= 1'b1;
        last_code      <= last_code_next;
        position_count <= position_count_next;
        dir_cw         <= dir_cw_next;
        dir_ccw        <= dir_ccw_next;
        applied_duty   <= applied_duty_next;
        chosen_duty    <= chosen_duty_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign position     = 32'(position_count);
  assign drive_cw     = dir_cw;
  assign drive_ccw    = dir_ccw;
  assign duty_out     = applied_duty;
  assign duty_setting = chosen_duty;

`ifndef SYNTHESIS
  a_pins_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(drive_cw && drive_ccw)) else $error("both drive pins high");

  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    in_accept && cmd == CMD_STOP |=> !drive_cw && !drive_ccw && duty_setting == '0
      && duty_out == '0) else $error("stop left drive active");

  a_load_position: assert property (@(posedge clk) disable iff (rst)
    in_accept && cmd == CMD_LOAD |=> position == $past(target))
    else $error("load did not set position");

  a_hold_state: assert property (@(posedge clk) disable iff (rst)
    !in_accept |=> $stable(position) && $stable(duty_setting) && $stable(duty_out))
    else $error("state moved without a request");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid) else $error("accepted request gave no result");
`endif

endmodule

`default_nettype wire
